// ===== rtl/ppv_pkg.sv =====
// Shared types, widths and register indexes for the point projection block.
package ppv_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC    = 16;
    localparam int COEF_W  = 32;
    localparam int DEPTH_W = 47;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int CLIP_W  = PROD_W - FRAC + 2;
    localparam int QB      = COORD_W + 1;
    localparam int PRE_SH  = QB - FRAC;
    localparam int T_W     = COORD_W + 3;
    localparam int SP_W    = T_W + PIX_W + 1;
    localparam int SV_W    = SP_W + 1;

    localparam logic [IDX_W-1:0] REG_X_LO   = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_HI   = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_LO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_HI   = 3'd3;
    localparam logic [IDX_W-1:0] REG_W_LO   = 3'd4;
    localparam logic [IDX_W-1:0] REG_W_HI   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ORIGIN = 3'd6;
    localparam logic [IDX_W-1:0] REG_SIZE   = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] x_lo;
        logic [CFG_W-1:0] x_hi;
        logic [CFG_W-1:0] y_lo;
        logic [CFG_W-1:0] y_hi;
        logic [CFG_W-1:0] w_lo;
        logic [CFG_W-1:0] w_hi;
        logic [2*PIX_W-1:0] origin;
        logic [2*PIX_W-1:0] size;
    } cfg_t;

    // one item inside the divider: remainders, numerator/quotient shift words
    typedef struct packed {
        logic               ok;
        logic               neg_x;
        logic               neg_y;
        logic [DEPTH_W-1:0] w;
        logic [DEPTH_W-1:0] rx;
        logic [DEPTH_W-1:0] ry;
        logic [QB-1:0]      bx;
        logic [QB-1:0]      by;
    } div_t;

endpackage

// ===== rtl/ppv_clip.sv =====
// Clip row products and sums, then divider setup (three stages).
module ppv_clip (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ppv_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ppv_pkg::COORD_W-1:0] pos_x,
    input  logic signed [ppv_pkg::COORD_W-1:0] pos_y,
    input  logic signed [ppv_pkg::COORD_W-1:0] pos_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ppv_pkg::div_t                     out_data
);
    localparam int PW = ppv_pkg::PROD_W;
    localparam int CW = ppv_pkg::CLIP_W;
    localparam int KW = ppv_pkg::COEF_W;
    localparam int DW = ppv_pkg::DEPTH_W;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic signed [PW-1:0] p_reg [9];
    logic signed [KW-1:0] k_reg [3];
    logic signed [CW-1:0] cx_reg, cy_reg, cw_reg;
    ppv_pkg::div_t d_reg;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v3_reg;
    assign out_data = d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // stage 1: nine coefficient products
    logic signed [KW-1:0] cf [9];
    logic signed [PW-1:0] prod [9];
    always_comb begin
        cf[0] = $signed(cfg.x_lo[KW-1:0]);
        cf[1] = $signed(cfg.x_lo[2*KW-1:KW]);
        cf[2] = $signed(cfg.x_hi[KW-1:0]);
        cf[3] = $signed(cfg.y_lo[KW-1:0]);
        cf[4] = $signed(cfg.y_lo[2*KW-1:KW]);
        cf[5] = $signed(cfg.y_hi[KW-1:0]);
        cf[6] = $signed(cfg.w_lo[KW-1:0]);
        cf[7] = $signed(cfg.w_lo[2*KW-1:KW]);
        cf[8] = $signed(cfg.w_hi[KW-1:0]);
    end

    // full-width products: operands sign-extend to the product width
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            prod[3*r]   = pos_x * cf[3*r];
            prod[3*r+1] = pos_y * cf[3*r+1];
            prod[3*r+2] = pos_z * cf[3*r+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            for (int i = 0; i < 9; i++) begin
                p_reg[i] <= prod[i];
            end
            k_reg[0] <= $signed(cfg.x_hi[2*KW-1:KW]);
            k_reg[1] <= $signed(cfg.y_hi[2*KW-1:KW]);
            k_reg[2] <= $signed(cfg.w_hi[2*KW-1:KW]);
        end
    end

    // stage 2: floor products to fraction width, sum row with constant
    logic signed [CW-1:0] row [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row[r] = CW'(p_reg[3*r] >>> ppv_pkg::FRAC)
                   + CW'(p_reg[3*r+1] >>> ppv_pkg::FRAC)
                   + CW'(p_reg[3*r+2] >>> ppv_pkg::FRAC)
                   + CW'(k_reg[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cx_reg <= row[0];
            cy_reg <= row[1];
            cw_reg <= row[2];
        end
    end

    // stage 3: w range, magnitudes, quotient overflow and initial remainders
    logic [CW-1:0] mag_x, mag_y, hi_x, hi_y;
    logic          w_ok, ov_x, ov_y;
    ppv_pkg::div_t d_next;
    always_comb begin
        mag_x = cx_reg[CW-1] ? CW'(-cx_reg) : cx_reg;
        mag_y = cy_reg[CW-1] ? CW'(-cy_reg) : cy_reg;
        w_ok  = !cw_reg[CW-1] && (cw_reg[CW-2:DW] == '0) && (cw_reg[DW-1:0] != '0);
        hi_x  = mag_x >> ppv_pkg::PRE_SH;
        hi_y  = mag_y >> ppv_pkg::PRE_SH;
        ov_x  = hi_x >= CW'(cw_reg[DW-1:0]);
        ov_y  = hi_y >= CW'(cw_reg[DW-1:0]);
        d_next.ok    = w_ok && !ov_x && !ov_y;
        d_next.neg_x = cx_reg[CW-1];
        d_next.neg_y = cy_reg[CW-1];
        d_next.w     = cw_reg[DW-1:0];
        d_next.rx    = hi_x[DW-1:0];
        d_next.ry    = hi_y[DW-1:0];
        d_next.bx    = {mag_x[ppv_pkg::PRE_SH-1:0], {ppv_pkg::FRAC{1'b0}}};
        d_next.by    = {mag_y[ppv_pkg::PRE_SH-1:0], {ppv_pkg::FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) d_reg <= d_next;
    end
endmodule

// ===== rtl/ppv_div_step.sv =====
// One restoring division step for both axes, one quotient bit per stage.
module ppv_div_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppv_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ppv_pkg::div_t out_data
);
    localparam int DW = ppv_pkg::DEPTH_W;
    localparam int QB = ppv_pkg::QB;

    logic          v_reg;
    ppv_pkg::div_t d_reg;
    ppv_pkg::div_t d_next;
    logic [DW:0]   sx, sy;
    logic          gx, gy;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb begin
        sx = {in_data.rx, in_data.bx[QB-1]};
        sy = {in_data.ry, in_data.by[QB-1]};
        gx = sx >= {1'b0, in_data.w};
        gy = sy >= {1'b0, in_data.w};
        d_next    = in_data;
        d_next.rx = gx ? DW'(sx - {1'b0, in_data.w}) : sx[DW-1:0];
        d_next.ry = gy ? DW'(sy - {1'b0, in_data.w}) : sy[DW-1:0];
        d_next.bx = {in_data.bx[QB-2:0], gx};
        d_next.by = {in_data.by[QB-2:0], gy};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (in_ready) v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) d_reg <= d_next;
    end
endmodule

// ===== rtl/ppv_screen.sv =====
// Quotient range check, viewport scale and offset, output register (three stages).
module ppv_screen (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ppv_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ppv_pkg::div_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               valid_res,
    output logic signed [ppv_pkg::COORD_W-1:0] screen_x,
    output logic signed [ppv_pkg::COORD_W-1:0] screen_y,
    output logic        [ppv_pkg::DEPTH_W-1:0] depth
);
    localparam int QB = ppv_pkg::QB;
    localparam int TW = ppv_pkg::T_W;
    localparam int SP = ppv_pkg::SP_W;
    localparam int SV = ppv_pkg::SV_W;
    localparam int CO = ppv_pkg::COORD_W;
    localparam int PX = ppv_pkg::PIX_W;
    localparam logic [QB-1:0] LIM = QB'(1) << (CO - 1);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // stage 1: signed ndc plus one
    logic signed [TW-1:0] tx_reg, ty_reg, tx_next, ty_next;
    logic ok1_reg, ok1_next;
    logic [ppv_pkg::DEPTH_W-1:0] w1_reg, w2_reg;
    always_comb begin
        tx_next = (in_data.neg_x ? -$signed(TW'(in_data.bx)) : $signed(TW'(in_data.bx)))
                + $signed(TW'(1) << ppv_pkg::FRAC);
        ty_next = (in_data.neg_y ? -$signed(TW'(in_data.by)) : $signed(TW'(in_data.by)))
                + $signed(TW'(1) << ppv_pkg::FRAC);
        ok1_next = in_data.ok
                && (in_data.neg_x ? (in_data.bx <= LIM) : (in_data.bx < LIM))
                && (in_data.neg_y ? (in_data.by <= LIM) : (in_data.by < LIM));
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            ok1_reg <= ok1_next;
            w1_reg  <= in_data.w;
        end
    end

    // stage 2: scale by viewport size
    logic signed [SP-1:0] px_reg, py_reg, px_next, py_next;
    logic ok2_reg;
    always_comb begin
        px_next = tx_reg * $signed({1'b0, cfg.size[PX-1:0]});
        py_next = ty_reg * $signed({1'b0, cfg.size[2*PX-1:PX]});
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            ok2_reg <= ok1_reg;
            w2_reg  <= w1_reg;
        end
    end

    // stage 3: halve with floor, add origin, range check
    logic signed [SV-1:0] vx, vy;
    logic ok3;
    always_comb begin
        vx = (SV'($signed(cfg.origin[PX-1:0])) <<< ppv_pkg::FRAC) + SV'(px_reg >>> 1);
        vy = (SV'($signed(cfg.origin[2*PX-1:PX])) <<< ppv_pkg::FRAC) + SV'(py_reg >>> 1);
        ok3 = ok2_reg
           && (vx >= -(SV'(1) <<< (CO - 1))) && (vx < (SV'(1) <<< (CO - 1)))
           && (vy >= -(SV'(1) <<< (CO - 1))) && (vy < (SV'(1) <<< (CO - 1)));
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            valid_res <= ok3;
            screen_x  <= ok3 ? vx[CO-1:0] : '0;
            screen_y  <= ok3 ? vy[CO-1:0] : '0;
            depth     <= ok3 ? w2_reg : '0;
        end
    end
endmodule

// ===== rtl/point_projection_to_viewport.sv =====
// Top level: configuration registers and the projection pipeline.
// Projects one signed Q16.16 world point per cycle through the x, y and w
// rows of the view-projection matrix and maps it to screen pixels. Points
// pass the row products and divider setup, the one-bit-per-stage restoring
// dividers (x and y side by side against clip w), then the viewport scale
// and the output register. A new request is accepted every cycle unless the
// full pipeline is stalled at the output; each stage holds its request on a
// stall, so bubbles ahead of a stalled result still fill. Configuration writes
// take effect at once and must only be made while the pipeline is empty.
module point_projection_to_viewport (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ppv_pkg::IDX_W-1:0]          cfg_index,
    input  logic [ppv_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ppv_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [ppv_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [ppv_pkg::COORD_W-1:0] s_pos_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_valid_res,
    output logic signed [ppv_pkg::COORD_W-1:0] m_screen_x,
    output logic signed [ppv_pkg::COORD_W-1:0] m_screen_y,
    output logic        [ppv_pkg::DEPTH_W-1:0] m_depth
);
    localparam int QB = ppv_pkg::QB;

    ppv_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_lo   <= 64'd65536;
            cfg_reg.x_hi   <= '0;
            cfg_reg.y_lo   <= 64'd1 << 48;
            cfg_reg.y_hi   <= '0;
            cfg_reg.w_lo   <= '0;
            cfg_reg.w_hi   <= 64'd1 << 48;
            cfg_reg.origin <= '0;
            cfg_reg.size   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppv_pkg::REG_X_LO:   cfg_reg.x_lo   <= cfg_wr_data;
                ppv_pkg::REG_X_HI:   cfg_reg.x_hi   <= cfg_wr_data;
                ppv_pkg::REG_Y_LO:   cfg_reg.y_lo   <= cfg_wr_data;
                ppv_pkg::REG_Y_HI:   cfg_reg.y_hi   <= cfg_wr_data;
                ppv_pkg::REG_W_LO:   cfg_reg.w_lo   <= cfg_wr_data;
                ppv_pkg::REG_W_HI:   cfg_reg.w_hi   <= cfg_wr_data;
                ppv_pkg::REG_ORIGIN: cfg_reg.origin <= cfg_wr_data[31:0];
                ppv_pkg::REG_SIZE:   cfg_reg.size   <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    logic          dv [QB+1];
    logic          dr [QB+1];
    ppv_pkg::div_t dd [QB+1];

    ppv_clip u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .pos_z     (s_pos_z),
        .out_valid (dv[0]),
        .out_ready (dr[0]),
        .out_data  (dd[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_div
        ppv_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv[i]),
            .in_ready  (dr[i]),
            .in_data   (dd[i]),
            .out_valid (dv[i+1]),
            .out_ready (dr[i+1]),
            .out_data  (dd[i+1])
        );
    end

    ppv_screen u_screen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (dv[QB]),
        .in_ready  (dr[QB]),
        .in_data   (dd[QB]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .valid_res (m_valid_res),
        .screen_x  (m_screen_x),
        .screen_y  (m_screen_y),
        .depth     (m_depth)
    );

    // input only backs up when every stage is full, so a result must be waiting
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_screen_x == '0 && m_screen_y == '0
                                       && m_depth == '0))
        else $error("invalid result carries nonzero fields");

    a_valid_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> (m_depth != '0))
        else $error("valid result with zero depth");
endmodule

// ===== tb/ppv_checker.sv =====
// Checker: watches both channels, predicts each projection and compares fields.
module ppv_checker
    import ppv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_valid_res,
    input  logic signed [COORD_W-1:0] m_screen_x,
    input  logic signed [COORD_W-1:0] m_screen_y,
    input  logic [DEPTH_W-1:0]        m_depth,
    output int                        fail_count,
    output int                        pending,
    output int                        n_valid_seen,
    output int                        n_invalid_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic [DEPTH_W-1:0]        depth;
    } proj_t;

    logic [CFG_W-1:0] regs [8];
    proj_t            want_q [$];

    function automatic longint floor_div2n(longint v, int s);
        return v >>> s;  // arithmetic shift floors
    endfunction

    function automatic longint coef(logic [CFG_W-1:0] r, bit upper);
        logic signed [31:0] c;
        c = upper ? r[63:32] : r[31:0];
        return longint'(c);
    endfunction

    function automatic longint row_sum(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                                       longint x, longint y, longint z);
        return floor_div2n(x * coef(lo, 0), FRAC) + floor_div2n(y * coef(lo, 1), FRAC)
             + floor_div2n(z * coef(hi, 0), FRAC) + coef(hi, 1);
    endfunction

    function automatic bit ndc_quot(longint num, longint w, output longint q);
        longint unsigned mag, qi, r, qm, lim;
        mag = (num < 0) ? longint'(-num) : num;
        qi  = mag / w;
        r   = mag % w;
        lim = 64'd1 << (COORD_W - 1);
        q   = 0;
        if (qi > (64'd1 << (COORD_W - 1 - FRAC))) return 0;
        qm = (qi << FRAC) + (r << FRAC) / w;
        if (num >= 0 ? (qm > lim - 1) : (qm > lim)) return 0;
        q = (num < 0) ? -longint'(qm) : longint'(qm);
        return 1;
    endfunction

    function automatic bit pix_map(longint ndc, longint org, longint sz, output longint s);
        longint lim;
        lim = longint'(1) << (COORD_W - 1);
        s = org * (longint'(1) << FRAC) + floor_div2n((ndc + (longint'(1) << FRAC)) * sz, 1);
        return !(s < -lim || s > lim - 1);
    endfunction

    function automatic proj_t project(longint x, longint y, longint z);
        proj_t  p;
        longint cx, cy, cw, nx, ny, sx, sy, ox, oy;
        logic signed [15:0] o16x, o16y;
        bit ok;
        cx = row_sum(regs[REG_X_LO], regs[REG_X_HI], x, y, z);
        cy = row_sum(regs[REG_Y_LO], regs[REG_Y_HI], x, y, z);
        cw = row_sum(regs[REG_W_LO], regs[REG_W_HI], x, y, z);
        o16x = regs[REG_ORIGIN][15:0];
        o16y = regs[REG_ORIGIN][31:16];
        ox = o16x;
        oy = o16y;
        ok = (cw >= 1) && (cw <= (longint'(1) << DEPTH_W) - 1);
        ok = ok && ndc_quot(cx, cw, nx) && ndc_quot(cy, cw, ny);
        ok = ok && pix_map(nx, ox, longint'(regs[REG_SIZE][15:0]), sx)
                && pix_map(ny, oy, longint'(regs[REG_SIZE][31:16]), sy);
        p = '0;
        if (ok) begin
            p.ok = 1'b1;
            p.sx = sx[COORD_W-1:0];
            p.sy = sy[COORD_W-1:0];
            p.depth = cw[DEPTH_W-1:0];
        end
        return p;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] exp);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, exp);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        proj_t w;
        if (!aresetn) begin
            regs[0] <= 64'd65536;
            regs[1] <= '0;
            regs[2] <= 64'd1 << 48;
            regs[3] <= '0;
            regs[4] <= '0;
            regs[5] <= 64'd1 << 48;
            regs[6] <= '0;
            regs[7] <= '0;
            want_q.delete();
            fail_count     = 0;
            n_valid_seen   = 0;
            n_invalid_seen = 0;
            pending        = 0;
        end else begin
            if (cfg_wr_en)
                regs[cfg_index] <= (cfg_index >= REG_ORIGIN) ? {32'd0, cfg_wr_data[31:0]}
                                                             : cfg_wr_data;
            if (s_valid && s_ready)
                want_q.insert(want_q.size(), project(s_pos_x, s_pos_y, s_pos_z));
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    report("result with no request pending", m_screen_x, 0);
                end else begin
                    w = want_q.pop_front();
                    if (m_valid_res !== w.ok) report("valid_res", m_valid_res, w.ok);
                    if (m_screen_x !== w.sx) report("screen_x", m_screen_x, w.sx);
                    if (m_screen_y !== w.sy) report("screen_y", m_screen_y, w.sy);
                    if (m_depth !== w.depth) report("depth", m_depth, w.depth);
                    if (w.ok) n_valid_seen++;
                    else n_invalid_seen++;
                end
            end
            pending = want_q.size();
        end
    end
endmodule

// ===== tb/point_projection_to_viewport_tb.sv =====
// Testbench top: drives points and configuration phases, gives the verdict.
module point_projection_to_viewport_tb;
    import ppv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 39;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [31:0] EDGE_PTS [6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                                             32'h8000_0000, 32'h0001_0000};

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_valid_res;
    logic signed [COORD_W-1:0] m_screen_x, m_screen_y;
    logic [DEPTH_W-1:0]        m_depth;
    int                        fail_count, pending, n_valid_seen, n_invalid_seen;
    longint                    cycles = 0;
    bit                        no_idle = 1'b0;
    int                        n_sent = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    point_projection_to_viewport dut (.*);

    ppv_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("point_projection_to_viewport: mismatch");
            $finish;
        end
    end

    // result side stalls at random except in the no-idle stretch
    always @(posedge aclk)
        m_ready <= no_idle || ($urandom_range(99) >= 32);

    // the write enable is dropped by the next send_point
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        cfg_wr_en <= 1'b0;
        while (!no_idle && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                              : 32'h8000_0000 + $urandom_range(3);
        endcase
    endfunction

    function automatic logic [31:0] rnd_coef(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(262144)) - 131072;
            default: return 32'h1_0000;
        endcase
    endfunction

    task automatic random_config(int mode);
        write_reg(REG_X_LO, {rnd_coef(mode), rnd_coef(mode)});
        write_reg(REG_X_HI, {rnd_coef(mode), rnd_coef(mode)});
        write_reg(REG_Y_LO, {rnd_coef(mode), rnd_coef(mode)});
        write_reg(REG_Y_HI, {rnd_coef(mode), rnd_coef(mode)});
        write_reg(REG_W_LO, {rnd_coef(1), rnd_coef(1)});
        // w constant kept positive and large most of the time so points land
        write_reg(REG_W_HI, {($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000, 1),
                             rnd_coef(1)});
        write_reg(REG_ORIGIN, {$urandom, $urandom});
        write_reg(REG_SIZE, {$urandom, (mode == 0) ? $urandom : $urandom_range(32'hffff_ffff)});
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset matrix: w fixed at 1.0, size zero -> screen equals origin
        for (int i = 0; i < 6; i++) send_point(EDGE_PTS[i], EDGE_PTS[5 - i], EDGE_PTS[i]);
        drain();
        // behind the eye, zero w, overflow and full-size viewport
        write_reg(REG_W_LO, 64'h0);
        write_reg(REG_W_HI, {32'h0, 32'h0001_0000});
        write_reg(REG_ORIGIN, 64'h8000_7fff);
        write_reg(REG_SIZE, 64'hffff_ffff);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'hffff_0000);
        send_point(32'h0000_8000, 32'hffff_8000, 32'h0002_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h1234_5678, 32'hedcb_a988, 32'h7fff_ffff);
        drain();
        write_reg(REG_W_HI, {32'h7fff_ffff, 32'h7fff_ffff});
        write_reg(REG_W_LO, {32'h7fff_ffff, 32'h7fff_ffff});
        write_reg(REG_SIZE, 64'h0);
        write_reg(REG_ORIGIN, 64'h0);
        for (int i = 0; i < 6; i++) send_point(EDGE_PTS[i], EDGE_PTS[i], EDGE_PTS[i]);
        drain();

        for (int phase = 0; phase < 11; phase++) begin
            random_config(phase % 3);
            no_idle = (phase == 5);
            for (int k = 0; k < 150; k++)
                send_point(rnd_coord($urandom_range(2)), rnd_coord($urandom_range(2)),
                           rnd_coord($urandom_range(2)));
            drain();
        end
        no_idle = 1'b0;

        $display("sent %0d points over 14 configuration phases", n_sent);
        $display("results: %0d projected, %0d flagged invalid", n_valid_seen, n_invalid_seen);
        if (fail_count == 0)
            $display("point_projection_to_viewport: match");
        else
            $display("point_projection_to_viewport: mismatch");
        $finish;
    end
endmodule
